// ===== rtl/core/obl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obl_pkg: shared types and constants of the octant line cell generator
// Field widths of the request and cell beats, the error term width and the
// octant mirror decode.
// ----------------------------------------------------------------------------
package obl_pkg;

  localparam int ORIGIN_W = 10;
  localparam int SPAN_IN_W = 5;
  localparam int OCT_W = 3;
  localparam int COORD_W = 12;
  // error term grows with rise above span; 12 bits cover every request
  localparam int ERR_W = 12;

  typedef logic [OCT_W-1:0] octant_t;

  typedef struct packed {
    logic swap;    // exchange dx and dy
    logic neg_x;   // subtract the column offset
    logic neg_y;   // subtract the row offset
  } mirror_t;

  localparam octant_t OCT_IDENT = 3'd0;
  localparam octant_t OCT_SWAP = 3'd1;
  localparam octant_t OCT_SWAP_NY = 3'd2;
  localparam octant_t OCT_NX = 3'd3;
  localparam octant_t OCT_NX_NY = 3'd4;
  localparam octant_t OCT_SWAP_NX_NY = 3'd5;
  localparam octant_t OCT_SWAP_NX = 3'd6;
  localparam octant_t OCT_NY = 3'd7;

  // decode an octant into swap and negate controls
  function automatic mirror_t mirror_decode(input octant_t oct);
    mirror_t m;
    unique case (oct)
      OCT_IDENT:      m = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b0};
      OCT_SWAP:       m = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b0};
      OCT_SWAP_NY:    m = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b1};
      OCT_NX:         m = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b0};
      OCT_NX_NY:      m = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b1};
      OCT_SWAP_NX_NY: m = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b1};
      OCT_SWAP_NX:    m = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b0};
      OCT_NY:         m = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b1};
      default:        m = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b0};
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/obl_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obl_req_if: line request channel
// Valid/ready channel that carries one line request per beat.
// ----------------------------------------------------------------------------
interface obl_req_if
  import obl_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [ORIGIN_W-1:0]  origin_x;
  logic [ORIGIN_W-1:0]  origin_y;
  logic [SPAN_IN_W-1:0] span_x;
  logic [SPAN_IN_W-1:0] rise_y;
  logic [OCT_W-1:0]     octant;

  modport source (output valid, origin_x, origin_y, span_x, rise_y, octant,
                  input ready);
  modport sink (input valid, origin_x, origin_y, span_x, rise_y, octant,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/core/obl_cell_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obl_cell_if: line cell channel
// Valid/ready channel that carries one mirrored cell per beat.
// ----------------------------------------------------------------------------
interface obl_cell_if
  import obl_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] cell_x;
  logic signed [COORD_W-1:0] cell_y;
  logic                      last_cell;

  modport source (output valid, cell_x, cell_y, last_cell, input ready);
  modport sink (input valid, cell_x, cell_y, last_cell, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/octant_bresenham_line_cells.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// octant_bresenham_line_cells: octant-mirrored Bresenham line cell generator
// Walks a first-octant line from an origin cell and mirrors each cell into
// one of eight octants.
// ----------------------------------------------------------------------------
// Usage:
//   req   - one beat per line: origin, span, rise and octant.
//   cells - one beat per cell, last_cell set on the final cell of the line.
//   A request of span s (saturated at MAX_SPAN) gives s-1 cells; a span
//   below 2 gives none and the request is simply consumed.
//   The first cell is registered from ST_RUN after the request beat, once the
//   cell register is free; then one cell is produced per cycle while the receiver
//   takes cells, through a single error-term adder under a two-state sequencer.
//   req.ready is low while a line is being walked.
//   The cell output register decouples the sides: the next request is
//   taken while the last cell of the previous line still waits.
//   When the receiver stalls, the walk holds with the cell register full.
//   Reset (rst, synchronous) drops any walk in progress and empties the
//   cell register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module octant_bresenham_line_cells
  import obl_pkg::*;
#(
  parameter int MAX_SPAN = 31
) (
  input  wire         clk,
  input  wire         rst,
  obl_req_if.sink     req,
  obl_cell_if.source  cells
);

  localparam int SW = $clog2(MAX_SPAN + 1);
  localparam int SAT_W = (SW > SPAN_IN_W) ? SW : SPAN_IN_W;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t                    state;
  logic [ORIGIN_W-1:0]       ox;
  logic [ORIGIN_W-1:0]       oy;
  logic [SW-1:0]             span;
  logic [SW-1:0]             dx;
  logic [SW-1:0]             dy;
  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W-1:0]   inc_up;
  logic signed [ERR_W-1:0]   inc_dn;
  mirror_t                   mir;

  logic                      out_valid;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic                      out_last;

  // saturate the incoming span
  logic [SAT_W-1:0]          span_wide;
  logic [SW-1:0]             span_sat;
  logic signed [ERR_W-1:0]   rise2_in;
  logic signed [ERR_W-1:0]   span_in;

  // step logic
  logic                      out_free;
  logic                      step;
  logic                      err_pos;
  logic signed [ERR_W-1:0]   err_next;
  logic [SW-1:0]             dy_next;
  logic [SW-1:0]             off_x;
  logic [SW-1:0]             off_y;
  logic signed [COORD_W-1:0] base_x;
  logic signed [COORD_W-1:0] base_y;
  logic signed [COORD_W-1:0] ext_x;
  logic signed [COORD_W-1:0] ext_y;
  logic signed [COORD_W-1:0] cx_next;
  logic signed [COORD_W-1:0] cy_next;
  logic                      last_next;
  logic                      req_fire;

  assign req.ready = (state == ST_IDLE) && !rst;
  assign req_fire = req.valid && req.ready;

  assign cells.valid = out_valid;
  assign cells.cell_x = out_x;
  assign cells.cell_y = out_y;
  assign cells.last_cell = out_last;

  // clamp span to MAX_SPAN
  always_comb begin
    span_wide = SAT_W'(req.span_x);
    if (span_wide > SAT_W'(MAX_SPAN)) begin
      span_sat = SW'(MAX_SPAN);
    end else begin
      span_sat = SW'(span_wide);
    end
    rise2_in = ERR_W'({req.rise_y, 1'b0});
    span_in = ERR_W'(span_sat);
  end

  // one Bresenham step and its mirrored cell
  always_comb begin
    out_free = !out_valid || cells.ready;
    step = (state == ST_RUN) && out_free;
    err_pos = (err > 0);
    err_next = err + (err_pos ? inc_up : inc_dn);
    dy_next = dy + SW'(err_pos);
    off_x = mir.swap ? dy_next : dx;
    off_y = mir.swap ? dx : dy_next;
    base_x = COORD_W'(ox);
    base_y = COORD_W'(oy);
    ext_x = COORD_W'(off_x);
    ext_y = COORD_W'(off_y);
    cx_next = mir.neg_x ? (base_x - ext_x) : (base_x + ext_x);
    cy_next = mir.neg_y ? (base_y - ext_y) : (base_y + ext_y);
    last_next = (dx == span - SW'(1));
  end

  // sequencer, walk registers and cell output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // drop a delivered cell unless a new one replaces it
      if (out_valid && cells.ready && !step) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_fire) begin
            ox <= req.origin_x;
            oy <= req.origin_y;
            span <= span_sat;
            mir <= mirror_decode(req.octant);
            err <= rise2_in - span_in;
            inc_dn <= rise2_in;
            inc_up <= rise2_in - (span_in <<< 1);
            dx <= SW'(1);
            dy <= '0;
            if (span_sat >= SW'(2)) begin
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (step) begin
            out_valid <= 1'b1;
            out_x <= cx_next;
            out_y <= cy_next;
            out_last <= last_next;
            err <= err_next;
            dy <= dy_next;
            dx <= dx + SW'(1);
            if (last_next) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
